FILE: sv/emgwfe_pkg.sv
// Package for the EMG window feature extractor: sizes, payload structs and lane control.
// Has no dependencies. All other source files but emgwfe_ram use it through scoped names.
package emgwfe_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int WINDOW_SIZE  = 50;
    localparam int NUM_CHANNELS = 4;
    localparam int SAMPLE_BITS  = 12;

    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam int WORD_W  = NUM_CHANNELS * SAMPLE_BITS;
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WIN_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W   = SAMPLE_BITS + WIN_W;
    localparam int D_W     = SUM_W + 1;
    localparam int ABS_W   = SUM_W + WIN_W;
    localparam int LEN_W   = SAMPLE_BITS + WIN_W;
    localparam int MAV_DIV = WINDOW_SIZE * WINDOW_SIZE;
    localparam int WL_DIV  = WINDOW_SIZE;

    // Q12.4 scaling: floor(16 * sum / div) as floor(16 * sum * recip / 2^sh), exact because
    // the scaled sum is below 2^N and sh = N + clog2(div)
    localparam int MAVN_W = ABS_W + 4;
    localparam int WLN_W  = LEN_W + 4;
    localparam int MAV_SH = MAVN_W + $clog2(MAV_DIV);
    localparam int WL_SH  = WLN_W + $clog2(WL_DIV);
    localparam longint MAV_RECIP = ((longint'(1) << MAV_SH) + longint'(MAV_DIV) - 1)
                                   / longint'(MAV_DIV);
    localparam longint WL_RECIP  = ((longint'(1) << WL_SH) + longint'(WL_DIV) - 1)
                                   / longint'(WL_DIV);

    typedef struct packed {
        logic [11:0] sample_ch0;
        logic [11:0] sample_ch1;
        logic [11:0] sample_ch2;
        logic [11:0] sample_ch3;
    } sample_set_t;

    typedef struct packed {
        logic [1:0]  channel_index;
        logic [15:0] mean_abs_value;
        logic [5:0]  zero_crossings;
        logic [15:0] waveform_length;
        logic [5:0]  turn_count;
        logic        last_channel;
    } feature_t;

    typedef struct packed {
        logic clr;
        logic sum_en;
        logic feat_en;
        logic has_prev;
        logic has_prev2;
    } lane_ctl_t;

endpackage

FILE: sv/emgwfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module emgwfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/emgwfe_div.sv
// Q12.4 scaling of one channel's feature sums by reciprocal multiplication: the sums are
// registered on start, then the products, and done rises with the result. Depends on emgwfe_pkg.
module emgwfe_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [emgwfe_pkg::ABS_W-1:0]    abs_sum,
    input  logic [emgwfe_pkg::LEN_W-1:0]    len_sum,
    output logic                            done,
    output logic [15:0]                     mav,
    output logic [15:0]                     wl
);

    localparam int AN = emgwfe_pkg::MAVN_W;
    localparam int AM = AN + 1;
    localparam int AP = AN + AM;
    localparam int AQ = AP - emgwfe_pkg::MAV_SH;
    localparam int WN = emgwfe_pkg::WLN_W;
    localparam int WM = WN + 1;
    localparam int WP = WN + WM;
    localparam int WQ = WP - emgwfe_pkg::WL_SH;

    localparam logic [AM-1:0] MAV_M = AM'(emgwfe_pkg::MAV_RECIP);
    localparam logic [WM-1:0] WL_M  = WM'(emgwfe_pkg::WL_RECIP);

    logic          busy_reg, done_reg;
    logic [AN-1:0] an_reg;
    logic [WN-1:0] ln_reg;
    logic [AP-1:0] ap_reg;
    logic [WP-1:0] lp_reg;
    logic [AQ-1:0] aq;
    logic [WQ-1:0] lq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            an_reg <= {abs_sum, 4'b0000};
            ln_reg <= {len_sum, 4'b0000};
        end
        if (busy_reg)
        begin
            ap_reg <= AP'(an_reg) * AP'(MAV_M);
            lp_reg <= WP'(ln_reg) * WP'(WL_M);
        end
    end

    assign aq   = ap_reg[AP-1:emgwfe_pkg::MAV_SH];
    assign lq   = lp_reg[WP-1:emgwfe_pkg::WL_SH];
    assign mav  = (aq > AQ'(16'hFFFF)) ? 16'hFFFF : aq[15:0];
    assign wl   = (lq > WQ'(16'hFFFF)) ? 16'hFFFF : lq[15:0];
    assign done = done_reg;

endmodule

FILE: sv/emgwfe_lane.sv
// One channel's accumulators: window sum on the first pass, features on the second.
// Depends on emgwfe_pkg.
module emgwfe_lane (
    input  logic                                  clk,
    input  emgwfe_pkg::lane_ctl_t                 ctl,
    input  logic [emgwfe_pkg::SAMPLE_BITS-1:0]    x,
    output logic [emgwfe_pkg::ABS_W-1:0]          abs_sum,
    output logic [emgwfe_pkg::LEN_W-1:0]          len_sum,
    output logic [5:0]                            zc,
    output logic [5:0]                            turns
);

    localparam int SB = emgwfe_pkg::SAMPLE_BITS;
    localparam int SW = emgwfe_pkg::SUM_W;
    localparam int DW = emgwfe_pkg::D_W;

    logic [SW-1:0]                 sum_reg, sum_next;
    logic [emgwfe_pkg::ABS_W-1:0]  abs_reg, abs_next;
    logic [emgwfe_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [5:0]                    zc_reg, zc_next, tn_reg, tn_next;
    logic [SB-1:0]                 px_reg, px_next;
    logic                          dpos_reg, dpos_next, dneg_reg, dneg_next;
    logic                          epos_reg, epos_next, eneg_reg, eneg_next;

    logic [DW-1:0]  wx;
    logic [DW-1:0]  d;
    logic [SW-1:0]  dabs;
    logic           dpos, dneg;
    logic [SB:0]    e;
    logic [SB-1:0]  eabs;
    logic           epos, eneg;

    always_comb
    begin
        wx   = DW'(x) * DW'(emgwfe_pkg::WINDOW_SIZE);
        d    = wx - DW'(sum_reg);
        dneg = d[DW-1];
        dpos = !d[DW-1] && (d != '0);
        dabs = dneg ? SW'(-d) : SW'(d);
        e    = {1'b0, x} - {1'b0, px_reg};
        eneg = e[SB];
        epos = !e[SB] && (e != '0);
        eabs = eneg ? SB'(-e) : SB'(e);

        sum_next  = sum_reg;
        abs_next  = abs_reg;
        len_next  = len_reg;
        zc_next   = zc_reg;
        tn_next   = tn_reg;
        px_next   = px_reg;
        dpos_next = dpos_reg;
        dneg_next = dneg_reg;
        epos_next = epos_reg;
        eneg_next = eneg_reg;
        if (ctl.clr)
        begin
            sum_next = '0;
            abs_next = '0;
            len_next = '0;
            zc_next  = '0;
            tn_next  = '0;
        end
        else if (ctl.sum_en)
        begin
            sum_next = sum_reg + SW'(x);
        end
        else if (ctl.feat_en)
        begin
            abs_next  = abs_reg + emgwfe_pkg::ABS_W'(dabs);
            px_next   = x;
            dpos_next = dpos;
            dneg_next = dneg;
            if (ctl.has_prev)
            begin
                len_next  = len_reg + emgwfe_pkg::LEN_W'(eabs);
                epos_next = epos;
                eneg_next = eneg;
                if ((dpos && dneg_reg) || (dneg && dpos_reg))
                begin
                    zc_next = zc_reg + 1'b1;
                end
                if (ctl.has_prev2 && ((epos && eneg_reg) || (eneg && epos_reg)))
                begin
                    tn_next = tn_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        abs_reg  <= abs_next;
        len_reg  <= len_next;
        zc_reg   <= zc_next;
        tn_reg   <= tn_next;
        px_reg   <= px_next;
        dpos_reg <= dpos_next;
        dneg_reg <= dneg_next;
        epos_reg <= epos_next;
        eneg_reg <= eneg_next;
    end

    assign abs_sum = abs_reg;
    assign len_sum = len_reg;
    assign zc      = zc_reg;
    assign turns   = tn_reg;

endmodule

FILE: sv/emg_window_feature_extractor.sv
// EMG window feature extractor, top level: ring memory, sequencer, lanes and scaler.
// Depends on emgwfe_pkg, emgwfe_ram, emgwfe_lane and emgwfe_div.

// Each request is written to a 64-entry ring. When it lands on the end mark the block walks the
// last 50 entries twice through the ring's single read port (all channels in parallel), then
// scales each channel's sums by reciprocal multiplication and offers its result. After the
// closing request the input is held until the last result is registered, and longer for any
// output stalls on the first three results. The last result waits in the output register while
// further requests are taken; only a request that would close the next window waits for it to
// go. Other requests are taken without a stall.
// The increment register may be written at any time the block is idle; cfg_ready is always high.
module emg_window_feature_extractor (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  emgwfe_pkg::sample_set_t in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output emgwfe_pkg::feature_t    out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [5:0]              cfg_data
);

    localparam int AW  = emgwfe_pkg::ADDR_W;
    localparam int CW  = emgwfe_pkg::CNT_W;
    localparam int NC  = emgwfe_pkg::NUM_CHANNELS;
    localparam int SB  = emgwfe_pkg::SAMPLE_BITS;
    localparam int DEP = emgwfe_pkg::RING_DEPTH;
    localparam int W   = emgwfe_pkg::WINDOW_SIZE;

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_FEAT, S_DSTART, S_DWAIT, S_OUT} state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  wp_reg, wp_next, em_reg, em_next, st_reg, st_next;
    logic [5:0]                     inc_reg, inc_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [emgwfe_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic                           ov_reg, ov_next;
    emgwfe_pkg::feature_t           od_reg, od_next;

    logic                           accept, fire;
    logic [AW:0]                    ra_sum, em_sum;
    logic [AW-1:0]                  raddr;
    logic [emgwfe_pkg::WORD_W-1:0]  wword, rword;
    emgwfe_pkg::lane_ctl_t          ctl;

    logic [emgwfe_pkg::ABS_W-1:0]   abs_sum [NC];
    logic [emgwfe_pkg::LEN_W-1:0]   len_sum [NC];
    logic [5:0]                     zc [NC];
    logic [5:0]                     turns [NC];

    logic                           sc_done, div_start;
    logic [15:0]                    mav_q, wl_q;

    assign accept    = in_valid && !in_stall;
    assign fire      = accept && (wp_reg == em_reg);
    // a window may not start while the previous window's last result is still pending
    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && (wp_reg == em_reg));
    assign cfg_ready = 1'b1;
    assign wword     = emgwfe_pkg::WORD_W'({in_data.sample_ch3[SB-1:0], in_data.sample_ch2[SB-1:0],
                                            in_data.sample_ch1[SB-1:0], in_data.sample_ch0[SB-1:0]});

    always_comb
    begin
        ra_sum = {1'b0, st_reg} + (AW + 1)'(cnt_reg);
        if (ra_sum >= (AW + 1)'(DEP))
        begin
            ra_sum = ra_sum - (AW + 1)'(DEP);
        end
        raddr  = ra_sum[AW-1:0];
        em_sum = {1'b0, em_reg} + (AW + 1)'(inc_reg);
        if (em_sum >= (AW + 1)'(DEP))
        begin
            em_sum = em_sum - (AW + 1)'(DEP);
        end
    end

    emgwfe_ram #(
        .WIDTH (emgwfe_pkg::WORD_W),
        .DEPTH (DEP)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (wword),
        .raddr (raddr),
        .rdata (rword)
    );

    always_comb
    begin
        ctl.clr       = fire;
        ctl.sum_en    = (state_reg == S_SUM) && (cnt_reg != '0);
        ctl.feat_en   = (state_reg == S_FEAT) && (cnt_reg != '0);
        ctl.has_prev  = (cnt_reg >= CW'(2));
        ctl.has_prev2 = (cnt_reg >= CW'(3));
    end

    for (genvar g = 0; g < NC; g++)
    begin : g_lane
        emgwfe_lane u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .x       (rword[g*SB +: SB]),
            .abs_sum (abs_sum[g]),
            .len_sum (len_sum[g]),
            .zc      (zc[g]),
            .turns   (turns[g])
        );
    end

    assign div_start = (state_reg == S_DSTART);

    emgwfe_div u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .abs_sum (abs_sum[ch_reg]),
        .len_sum (len_sum[ch_reg]),
        .done    (sc_done),
        .mav     (mav_q),
        .wl      (wl_q)
    );

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        em_next    = em_reg;
        st_next    = st_reg;
        inc_next   = inc_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        if (cfg_valid && cfg_ready)
        begin
            inc_next = cfg_data;
        end
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next = (wp_reg == AW'(DEP - 1)) ? '0 : wp_reg + 1'b1;
                    if (fire)
                    begin
                        em_next    = em_sum[AW-1:0];
                        st_next    = (wp_reg >= AW'(W - 1)) ? wp_reg - AW'(W - 1)
                                                            : AW'(32'(wp_reg) + DEP - (W - 1));
                        cnt_next   = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM, S_FEAT:
            begin
                if (cnt_reg == CW'(W))
                begin
                    cnt_next   = '0;
                    ch_next    = '0;
                    state_next = (state_reg == S_SUM) ? S_FEAT : S_DSTART;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sc_done)
                begin
                    od_next.channel_index   = 2'(ch_reg);
                    od_next.mean_abs_value  = mav_q;
                    od_next.zero_crossings  = zc[ch_reg];
                    od_next.waveform_length = wl_q;
                    od_next.turn_count      = turns[ch_reg];
                    od_next.last_channel    = (ch_reg == emgwfe_pkg::CH_W'(NC - 1));
                    ov_next                 = 1'b1;
                    // the final result is left in the output register
                    state_next              = (ch_reg == emgwfe_pkg::CH_W'(NC - 1)) ? S_IDLE
                                                                                     : S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_DSTART;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            em_reg    <= AW'((W - 1) % DEP);
            inc_reg   <= 6'd50;
            cnt_reg   <= '0;
            ch_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            em_reg    <= em_next;
            inc_reg   <= inc_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // no window may start while a result is pending
    a_no_fire_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && out_valid))
        else $error("window started while a result is pending");

    a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> in_stall)
        else $error("window evaluation did not start");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_channel) |=> !in_stall && !out_valid)
        else $error("block not idle after final channel");

    a_scale_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sc_done |-> (state_reg == S_DWAIT))
        else $error("scaler result outside its wait state");

endmodule

FILE: dv/tb_emg_window_feature_extractor.sv
// Testbench for emg_window_feature_extractor: directed and random sample sets, window-increment
// settings, random idling on both sides. Depends on emgwfe_pkg and the block's RTL only.
`timescale 1ns / 100ps

class feature_scoreboard;
    emgwfe_pkg::feature_t pending[$];
    logic [11:0] ring[64][4];
    int unsigned wr_ptr;
    int unsigned end_mark;
    int unsigned increment;
    int unsigned mismatches;
    int unsigned windows;
    int unsigned results;

    function new();
        wr_ptr = 0;
        end_mark = 49;
        increment = 50;
        mismatches = 0;
        windows = 0;
        results = 0;
    endfunction

    function void set_increment(logic [5:0] v);
        increment = 32'(v);
    endfunction

    function int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Note one accepted sample set; queue the four feature results when a window closes.
    function void note_sample(emgwfe_pkg::sample_set_t s);
        emgwfe_pkg::feature_t f;
        longint x[50];
        longint sum, d, dn, e, en, abs_sum, len_sum, q;
        int unsigned first, zc, turns;
        ring[wr_ptr][0] = s.sample_ch0;
        ring[wr_ptr][1] = s.sample_ch1;
        ring[wr_ptr][2] = s.sample_ch2;
        ring[wr_ptr][3] = s.sample_ch3;
        if (wr_ptr == end_mark) begin
            windows++;
            end_mark = (end_mark + increment) % 64;
            first = (wr_ptr + 64 - 49) % 64;
            for (int ch = 0; ch < 4; ch++) begin
                sum = 0;
                abs_sum = 0;
                len_sum = 0;
                zc = 0;
                turns = 0;
                for (int k = 0; k < 50; k++) begin
                    x[k] = ring[(first + k) % 64][ch];
                    sum += x[k];
                end
                for (int k = 0; k < 50; k++) begin
                    d = 50 * x[k] - sum;
                    abs_sum += (d < 0) ? -d : d;
                    if (k < 49) begin
                        dn = 50 * x[k + 1] - sum;
                        e = x[k + 1] - x[k];
                        if (sgn(d) * sgn(dn) < 0)
                            zc++;
                        len_sum += (e < 0) ? -e : e;
                        if (k < 48) begin
                            en = x[k + 2] - x[k + 1];
                            if (sgn(e) * sgn(en) < 0)
                                turns++;
                        end
                    end
                end
                f.channel_index = 2'(ch);
                q = (abs_sum * 16) / 2500;
                f.mean_abs_value = (q > 65535) ? 16'hffff : q[15:0];
                f.zero_crossings = zc[5:0];
                q = (len_sum * 16) / 50;
                f.waveform_length = (q > 65535) ? 16'hffff : q[15:0];
                f.turn_count = turns[5:0];
                f.last_channel = (ch == 3);
                pending.push_back(f);
            end
        end
        wr_ptr = (wr_ptr + 1) % 64;
    endfunction

    function void check_result(emgwfe_pkg::feature_t got);
        emgwfe_pkg::feature_t exp_f;
        results++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %p", got);
            return;
        end
        exp_f = pending.pop_front();
        if (got !== exp_f) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %p, actual %p", exp_f, got);
        end
    endfunction
endclass

module tb_emg_window_feature_extractor;
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    emgwfe_pkg::sample_set_t in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    emgwfe_pkg::feature_t    out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [5:0]              cfg_data = '0;

    feature_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned sent = 0;
    int          mode = 0;

    emg_window_feature_extractor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [11:0] pick_sample();
        int unsigned r;
        r = $urandom_range(9);
        case (mode)
            1: return (r < 5) ? 12'h000 : 12'hfff;
            2: return 12'(2048 + $urandom_range(40) - 20);
            default: return (r == 0) ? 12'h000 : ((r == 1) ? 12'hfff : 12'($urandom));
        endcase
    endfunction

    // Valid stays high after a request until the sender idles or stops
    task automatic send_sample(emgwfe_pkg::sample_set_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(s);
        sent++;
    endtask

    task automatic send_random(int unsigned n);
        emgwfe_pkg::sample_set_t s;
        for (int i = 0; i < n; i++) begin
            if (i % 20 == 0)
                mode = $urandom_range(2);
            s.sample_ch0 = pick_sample();
            s.sample_ch1 = pick_sample();
            s.sample_ch2 = pick_sample();
            s.sample_ch3 = pick_sample();
            send_sample(s);
        end
    endtask

    // Register writes only with nothing in flight; the guard covers the window work.
    task automatic write_increment(logic [5:0] v);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_increment(v);
    endtask

    initial
    begin
        emgwfe_pkg::sample_set_t s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, full scale, alternating extremes, ramp; first window at set 49
        for (int i = 0; i < 25; i++) begin
            case (i % 5)
                0: s = '0;
                1: s = '1;
                2: s = {12'hfff, 12'h000, 12'haaa, 12'h555};
                3: s = {12'h000, 12'hfff, 12'h555, 12'haaa};
                default: s = {4{12'(i * 160)}};
            endcase
            send_sample(s);
        end
        send_random(25);

        send_idle_pct = 36;
        recv_idle_pct = 59;
        write_increment(6'd1);
        send_random(20);
        write_increment(6'd63);
        send_random(70);

        send_idle_pct = 59;
        recv_idle_pct = 36;
        write_increment(6'd0);
        send_random(10);
        write_increment(6'd7);
        // Long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(30);
        join

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_increment(6'd13);
        send_random(30);
        in_valid <= 1'b0;

        fork
            begin
                while (sb.pending.size() != 0)
                    @(posedge clk);
                repeat (300) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                $display("timeout waiting for results");
                sb.mismatches++;
            end
        join_any
        $display("covered %0d sample sets, %0d windows, %0d results, increments 50/1/63/0/7/13",
                 sent, sb.windows, sb.results);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.pending.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
sv/emgwfe_pkg.sv
sv/emgwfe_ram.sv
sv/emgwfe_div.sv
sv/emgwfe_lane.sv
sv/emg_window_feature_extractor.sv
dv/tb_emg_window_feature_extractor.sv
